FILE: hdl/imh_pkg.sv
`timescale 1ns / 1ps

package imh_pkg;

  localparam int unsigned NumStages = 7;

  localparam logic [63:0] InvMul21  = 64'd14933078535860113213;
  localparam logic [63:0] InvMul265 = 64'd15244667743933553977;

  localparam int unsigned ShiftA = 21;
  localparam int unsigned XsA    = 24;
  localparam int unsigned XsB    = 14;
  localparam int unsigned XsC    = 28;
  localparam int unsigned ShiftD = 31;

  // Stage indexes of the pipeline.
  localparam int unsigned StgPrep   = 0;
  localparam int unsigned StgMulA   = 1;
  localparam int unsigned StgMulB   = 2;
  localparam int unsigned StgMulC   = 3;
  localparam int unsigned StgJoin   = 4;
  localparam int unsigned StgUndoA  = 5;
  localparam int unsigned StgFinish = 6;

  localparam logic ActForward = 1'b0;
  localparam logic ActInverse = 1'b1;

  // One pipeline word. p0..p2 carry the partial products of a split
  // 64-bit multiply, and p0 also holds a temporary of the last inverse step.
  typedef struct packed {
    logic        action;
    logic [63:0] x;
    logic [63:0] p0;
    logic [31:0] p1;
    logic [31:0] p2;
  } word_t;

  function automatic logic [63:0] width_mask(logic [5:0] k);
    logic [6:0] bits;
    bits = {k, 1'b0};
    if (k[5]) begin
      return '1;
    end
    return (64'd1 << bits) - 64'd1;
  endfunction

  // Low 64 bits of x * c need only three 32 x 32 products.
  function automatic word_t mul_split(word_t d, logic [63:0] c);
    word_t r;
    r = d;
    r.p0 = 64'(d.x[31:0] * c[31:0]);
    r.p1 = 32'(d.x[63:32] * c[31:0]);
    r.p2 = 32'(d.x[31:0] * c[63:32]);
    return r;
  endfunction

  function automatic logic [63:0] mul_join(word_t d);
    logic [31:0] mid;
    mid = d.p1 + d.p2;
    return d.p0 + {mid, 32'd0};
  endfunction

  function automatic word_t stage_fn(int unsigned idx, word_t d, logic [63:0] m);
    word_t       r;
    logic [63:0] x;
    logic [63:0] t;
    r = d;
    x = d.x;
    t = '0;
    case (idx)
      StgPrep: begin
        if (d.action == ActForward) begin
          r.x = (~x + (x << ShiftA)) & m;
        end else begin
          x = x & m;
          t = x - (x << ShiftD);
          r.x = (x - (t << ShiftD)) & m;
        end
      end
      StgMulA: begin
        if (d.action == ActForward) begin
          x = x ^ (x >> XsA);
          r.x = ((x << 8) + (x << 3) + x) & m;
        end else begin
          t = x ^ (x >> XsC);
          r.x = x ^ (t >> XsC);
          r = mul_split(r, InvMul21);
        end
      end
      StgMulB: begin
        if (d.action == ActForward) begin
          x = x ^ (x >> XsB);
          r.x = ((x << 4) + (x << 2) + x) & m;
        end else begin
          // Four rounds rebuild a right xorshift by 14 over 64 bits.
          x = mul_join(d) & m;
          t = x ^ (x >> XsB);
          t = x ^ (t >> XsB);
          t = x ^ (t >> XsB);
          r.x = x ^ (t >> XsB);
        end
      end
      StgMulC: begin
        if (d.action == ActForward) begin
          x = x ^ (x >> XsC);
          r.x = (x + (x << ShiftD)) & m;
        end else begin
          r = mul_split(d, InvMul265);
        end
      end
      StgJoin: begin
        if (d.action == ActInverse) begin
          x = mul_join(d) & m;
          t = x ^ (x >> XsA);
          r.x = x ^ (t >> XsA);
        end
      end
      StgUndoA: begin
        if (d.action == ActInverse) begin
          t = ~x;
          t = ~(x - (t << ShiftA));
          t = ~(x - (t << ShiftA));
          r.p0 = t;
        end
      end
      StgFinish: begin
        if (d.action == ActInverse) begin
          r.x = ~(x - (d.p0 << ShiftA)) & m;
        end
      end
      default: begin
        r = d;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/invertible_masked_hash.sv
`timescale 1ns / 1ps

// Masked invertible 64-bit integer hash with its exact inverse.
// Request channel: req_valid / req_stall carry action and key. action low
// hashes the key, action high recovers a key from a hash value. Response
// channel: rsp_valid / rsp_stall carry value. A beat moves at a clock edge
// with valid high and stall low.
// kmer_length (k) is written over cfg_valid / cfg_ready. The user must write
// it only while the block is idle; the block itself does not enforce this.
// All arithmetic is kept to the low 2k bits, and k of 32 or more uses all
// 64 bits. Reset sets k to 31 and empties the pipeline.
// The datapath is a seven-stage pipeline that takes one request every cycle
// while req_stall is low. The 64-bit multiplies of the inverse path are split
// into 32 x 32 partial products in one stage and summed in the next.
// When the receiver stalls, a full stage holds while the one after it holds;
// bubbles still close up, and req_stall rises only when all stages hold data.
module invertible_masked_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        action,
  input  logic [63:0] key,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [63:0] value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  kmer_length
);

  localparam int unsigned N = imh_pkg::NumStages;

  logic [5:0]     k;
  logic [63:0]    mask;
  logic [N-1:0]   vld;
  logic [N-1:0]   en;
  imh_pkg::word_t q [N];
  imh_pkg::word_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= 6'd31;
    end else if (cfg_valid && cfg_ready) begin
      k <= kmer_length;
    end
  end

  assign mask = imh_pkg::width_mask(k);

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[N-1] = !vld[N-1] || !rsp_stall;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_comb begin
    head        = '0;
    head.action = action;
    head.x      = key;
  end

  imh_stage #(
    .STAGE(0)
  ) u_stage0 (
    .clk   (clk),
    .rst   (rst),
    .en    (en[0]),
    .vld_in(req_valid),
    .d     (head),
    .mask  (mask),
    .vld   (vld[0]),
    .q     (q[0])
  );

  for (genvar g = 1; g < N; g++) begin : g_stage
    imh_stage #(
      .STAGE(g)
    ) u_stage (
      .clk   (clk),
      .rst   (rst),
      .en    (en[g]),
      .vld_in(vld[g-1]),
      .d     (q[g-1]),
      .mask  (mask),
      .vld   (vld[g]),
      .q     (q[g])
    );
  end

  assign req_stall = !en[0];
  assign rsp_valid = vld[N-1];
  assign value     = q[N-1].x;

  // Back pressure reaches the request side only when every stage is full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (&vld))
    else $error("request stalled while the pipeline has a bubble");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> vld[0])
    else $error("accepted request did not enter the first stage");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (vld[N-1] && rsp_stall) |=> (vld[N-1] && $stable(q[N-1].x)))
    else $error("stalled result was lost or changed");

endmodule

FILE: hdl/imh_stage.sv
`timescale 1ns / 1ps

module imh_stage #(
  parameter int unsigned STAGE = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vld_in,
  input  imh_pkg::word_t d,
  input  logic [63:0]    mask,
  output logic           vld,
  output imh_pkg::word_t q
);

  imh_pkg::word_t q_next;

  always_comb begin
    q_next = imh_pkg::stage_fn(STAGE, d, mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

FILE: verif/tb_invertible_masked_hash.sv
`timescale 1ns / 1ps

module tb_invertible_masked_hash;

  localparam int unsigned HoldCycles      = 80;
  localparam int unsigned DrainCycles     = 12;
  localparam int unsigned NoProgressLimit = 2000;
  localparam int unsigned MaxPrinted      = 100;

  localparam logic [63:0] InvOf21  = 64'd14933078535860113213;
  localparam logic [63:0] InvOf265 = 64'd15244667743933553977;

  typedef enum int unsigned {
    StallNone,
    StallRandom,
    StallPattern,
    StallHeavy
  } stall_mode_t;

  typedef struct {
    logic        action;
    logic [63:0] key;
    logic [5:0]  length;
    logic [63:0] value;
  } hash_result_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        req_valid   = 1'b0;
  logic        req_stall;
  logic        action      = 1'b0;
  logic [63:0] key         = '0;
  logic        rsp_valid;
  logic        rsp_stall   = 1'b0;
  logic [63:0] value;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic [5:0]  kmer_length = '0;

  hash_result_t expected_hashes[$];
  logic [5:0]   active_length = 6'd31;
  int unsigned  mismatches = 0;

  stall_mode_t  rsp_stall_mode = StallNone;
  int unsigned  hold_requests = 0;
  int unsigned  hold_seen = 0;
  int unsigned  hold_left = 0;
  int unsigned  stall_tick = 0;

  int unsigned  sender_max_gap = 0;
  int unsigned  burst_left = 0;
  int unsigned  idle_cycles = 0;

  invertible_masked_hash i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .action     (action),
    .key        (key),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .kmer_length(kmer_length)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Hash predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] length_mask(logic [5:0] len);
    logic [63:0] ones;
    ones = '1;
    if (len >= 6'd32) begin
      return ones;
    end
    return ~(ones << (2 * len));
  endfunction

  function automatic logic [63:0] forward_hash(logic [63:0] x, logic [63:0] m);
    x = (~x + (x << 21)) & m;
    x = x ^ (x >> 24);
    x = (x * 64'd265) & m;
    x = x ^ (x >> 14);
    x = (x * 64'd21) & m;
    x = x ^ (x >> 28);
    x = (x + (x << 31)) & m;
    return x;
  endfunction

  function automatic logic [63:0] inverse_hash(logic [63:0] x, logic [63:0] m);
    logic [63:0] t;
    x = x & m;
    t = x - (x << 31);
    x = (x - (t << 31)) & m;
    t = x ^ (x >> 28);
    x = x ^ (t >> 28);
    x = (x * InvOf21) & m;
    // A right xorshift by 14 needs four rounds to undo over 64 bits.
    t = x ^ (x >> 14);
    t = x ^ (t >> 14);
    t = x ^ (t >> 14);
    x = x ^ (t >> 14);
    x = (x * InvOf265) & m;
    t = x ^ (x >> 24);
    x = x ^ (t >> 24);
    t = ~x;
    t = ~(x - (t << 21));
    t = ~(x - (t << 21));
    x = ~(x - (t << 21)) & m;
    return x;
  endfunction

  function automatic logic [63:0] hash_value(logic act, logic [63:0] k_in, logic [5:0] len);
    if (act == imh_pkg::ActForward) begin
      return forward_hash(k_in, length_mask(len));
    end
    return inverse_hash(k_in, length_mask(len));
  endfunction

  function automatic logic [63:0] random_key();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = '1;
      2: r = 64'd1 << $urandom_range(0, 63);
      3: r = 64'($urandom_range(0, 255));
      4: r = ~(64'd1 << $urandom_range(0, 63));
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("%0t ns: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin : check_results
    hash_result_t exp_r;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing outstanding", value));
      end else begin
        exp_r = expected_hashes.pop_front();
        if (value !== exp_r.value) begin
          report_mismatch($sformatf("action %0d key %h k %0d: value %h, expected %h",
                                    exp_r.action, exp_r.key, exp_r.length, value,
                                    exp_r.value));
        end
      end
    end
  end

  // Ends the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= NoProgressLimit) begin
      $display("timeout: no beat moved for %0d cycles", NoProgressLimit);
      $display("FAIL invertible_masked_hash");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    stall_tick++;
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      case (rsp_stall_mode)
        StallNone:    rsp_stall <= 1'b0;
        StallRandom:  rsp_stall <= ($urandom_range(0, 9) < 3);
        StallPattern: rsp_stall <= ((stall_tick % 7) < 3);
        StallHeavy:   rsp_stall <= ($urandom_range(0, 9) < 8);
        default:      rsp_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration
  // ---------------------------------------------------------------------------

  // Called at a clock edge; returns at the edge where the beat was taken.
  task automatic send_key(logic act, logic [63:0] k_in);
    int unsigned gap;
    hash_result_t r;
    if (sender_max_gap != 0 && burst_left == 0) begin
      gap = $urandom_range(1, sender_max_gap);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    req_valid <= 1'b1;
    action    <= act;
    key       <= k_in;
    do begin
      @(posedge clk);
    end while (req_stall);
    r.action = act;
    r.key    = k_in;
    r.length = active_length;
    r.value  = hash_value(act, k_in, active_length);
    expected_hashes.push_back(r);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_hashes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_kmer_length(logic [5:0] len);
    wait_drained();
    cfg_valid   <= 1'b1;
    kmer_length <= len;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    active_length = len;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Runs at the length that reset leaves behind.
  task automatic test_reset_length();
    sender_max_gap = 0;
    rsp_stall_mode = StallNone;
    send_key(imh_pkg::ActForward, 64'd0);
    send_key(imh_pkg::ActForward, '1);
    send_key(imh_pkg::ActInverse, 64'd0);
    send_key(imh_pkg::ActInverse, '1);
    send_key(imh_pkg::ActForward, 64'h8000_0000_0000_0000);
    send_key(imh_pkg::ActInverse, 64'h3FFF_FFFF_FFFF_FFFF);
  endtask

  // Zero length, the shortest nonzero length, the full width and an overlong
  // length. At the short lengths the alternating keys carry bits above the mask that must not matter.
  task automatic test_length_extremes();
    logic [5:0] lengths[4];
    lengths = '{6'd0, 6'd1, 6'd32, 6'd63};
    foreach (lengths[i]) begin
      set_kmer_length(lengths[i]);
      send_key(imh_pkg::ActForward, '1);
      send_key(imh_pkg::ActInverse, '1);
      send_key(imh_pkg::ActForward, 64'hAAAA_AAAA_AAAA_AAAA);
      send_key(imh_pkg::ActInverse, 64'h5555_5555_5555_5555);
    end
  endtask

  // Hash a key and then unhash the expected hash right behind it.
  task automatic test_round_trip();
    logic [63:0] k_in;
    sender_max_gap = 3;
    rsp_stall_mode = StallRandom;
    for (int p = 0; p < 5; p++) begin
      set_kmer_length(p == 0 ? 6'd32 : 6'($urandom_range(1, 32)));
      for (int i = 0; i < 10; i++) begin
        k_in = random_key();
        send_key(imh_pkg::ActForward, k_in);
        send_key(imh_pkg::ActInverse,
                 hash_value(imh_pkg::ActForward, k_in, active_length));
      end
    end
  endtask

  task automatic test_random_mix();
    logic [63:0] k_in;
    logic [5:0]  len;
    int unsigned gaps[3];
    gaps = '{0, 3, 15};
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: len = 6'd1;
        1: len = 6'd32;
        2: len = 6'd0;
        3: len = 6'd63;
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            len = 6'($urandom_range(33, 63));
          end else begin
            len = 6'($urandom_range(1, 32));
          end
        end
      endcase
      set_kmer_length(len);
      if (p == 0) begin
        sender_max_gap = 0;
        rsp_stall_mode = StallNone;
      end else begin
        sender_max_gap = gaps[$urandom_range(0, 2)];
        rsp_stall_mode = stall_mode_t'($urandom_range(0, 3));
      end
      for (int i = 0; i < 60; i++) begin
        k_in = random_key();
        if ($urandom_range(0, 1) == 0) begin
          send_key(imh_pkg::ActForward, k_in);
        end else if ($urandom_range(0, 1) == 0) begin
          send_key(imh_pkg::ActInverse,
                   hash_value(imh_pkg::ActForward, k_in, active_length));
        end else begin
          send_key(imh_pkg::ActInverse, k_in);
        end
        // Now and then the sender waits for every outstanding result.
        if ($urandom_range(0, 99) == 0) begin
          wait_drained();
        end
      end
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and push
  // back on the request side while beats keep being offered.
  task automatic test_full_backpressure();
    set_kmer_length(6'd31);
    sender_max_gap = 0;
    rsp_stall_mode = StallNone;
    hold_requests++;
    for (int i = 0; i < 40; i++) begin
      send_key(1'($urandom_range(0, 1)), random_key());
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_length();
    test_length_extremes();
    test_round_trip();
    test_random_mix();
    test_full_backpressure();
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS invertible_masked_hash");
    end else begin
      $display("FAIL invertible_masked_hash");
    end
    $finish;
  end

endmodule
